>>> sv/sod_pkg.sv
// ----------------------------------------------------------------------------
// sod_pkg
// Shared types and constants of the segmentation overlap scorer: counter
// widths, score format, pixel classes, job and result records.
// ----------------------------------------------------------------------------
package sod_pkg;

  // Score format: unsigned fixed point, 1 << SCORE_FRAC_BITS is 1.0
  localparam int SCORE_FRAC_BITS = 16;
  localparam int SCORE_W         = SCORE_FRAC_BITS + 1;

  // Counter widths
  localparam int SLICE_CNT_W = 21;
  localparam int VOL_CNT_W   = 28;

  // Divider operand widths, sized for Dice: num = 2*TP, den = 2*TP + FP + FN
  localparam int NUM_W  = VOL_CNT_W + 1;
  localparam int DEN_W  = VOL_CNT_W + 2;
  localparam int DIV_W  = DEN_W + SCORE_FRAC_BITS;
  localparam int STEP_W = $clog2(SCORE_W);

  // Queue geometry shared by the job queue and the result queue
  localparam int QDEPTH = 2;
  localparam int PTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  localparam logic [7:0] CHANNEL_ON = 8'd255;

  // Result kinds
  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_SLICE  = 2'd1;
  localparam logic [1:0] KIND_VOLUME = 2'd2;

  typedef enum logic [1:0] {
    CLS_TN,
    CLS_TP,
    CLS_FN,
    CLS_FP
  } pix_class_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DICE_GO,
    B_DICE_WAIT,
    B_JAC_GO,
    B_JAC_WAIT,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [SLICE_CNT_W-1:0] tp;
    logic [SLICE_CNT_W-1:0] fp;
    logic [SLICE_CNT_W-1:0] tn;
    logic [SLICE_CNT_W-1:0] fn;
  } slice_cnt_t;

  typedef struct packed {
    logic [VOL_CNT_W-1:0] tp;
    logic [VOL_CNT_W-1:0] fp;
    logic [VOL_CNT_W-1:0] tn;
    logic [VOL_CNT_W-1:0] fn;
  } vol_cnt_t;

  // One classified pixel with the counter snapshot taken after counting it
  typedef struct packed {
    pix_class_e cls;
    logic       slice_end;
    logic       volume_end;
    slice_cnt_t slice_cnt;
    vol_cnt_t   vol_cnt;
  } job_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SCORE_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic [7:0]           blue;
    logic [7:0]           green;
    logic [7:0]           red;
    logic [VOL_CNT_W-1:0] tp;
    logic [VOL_CNT_W-1:0] fp;
    logic [VOL_CNT_W-1:0] tn;
    logic [VOL_CNT_W-1:0] fn;
    logic [SCORE_W-1:0]   dice;
    logic [SCORE_W-1:0]   jac;
    logic                 valid;
    logic                 last;
  } result_t;

endpackage

>>> sv/sod_front.sv
// ----------------------------------------------------------------------------
// sod_front
// Accepts pixel pairs, classifies them, keeps the saturating slice and
// volume counters and hands one job per pixel to the job queue.
// ----------------------------------------------------------------------------
module sod_front import sod_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] segmented_value_i,
  input  logic [15:0] truth_value_i,
  input  logic        slice_end_i,
  input  logic        volume_end_i,
  input  logic        push_i,
  output logic        full_o,
  output logic        q_push_o,
  output job_t        q_job_o,
  input  logic        q_full_i
);

  slice_cnt_t slice_q, slice_d, slice_upd;
  vol_cnt_t   vol_q, vol_d, vol_upd;
  pix_class_e cls;
  logic       seg_pos, gt_pos, accept;

  function automatic logic [SLICE_CNT_W-1:0] sat_slice(input logic [SLICE_CNT_W-1:0] v);
    return (&v) ? v : v + SLICE_CNT_W'(1);
  endfunction

  function automatic logic [VOL_CNT_W-1:0] sat_vol(input logic [VOL_CNT_W-1:0] v);
    return (&v) ? v : v + VOL_CNT_W'(1);
  endfunction

  assign accept   = push_i && !q_full_i;
  assign full_o   = q_full_i;
  assign q_push_o = accept;

  // Classify the pixel pair
  assign seg_pos = |segmented_value_i;
  assign gt_pos  = |truth_value_i;

  always_comb begin
    if (gt_pos && seg_pos) begin
      cls = CLS_TP;
    end else if (gt_pos) begin
      cls = CLS_FN;
    end else if (seg_pos) begin
      cls = CLS_FP;
    end else begin
      cls = CLS_TN;
    end
  end

  // Count the pixel, build the job, clear counters after their summary
  always_comb begin
    slice_upd = slice_q;
    vol_upd   = vol_q;
    case (cls)
      CLS_TP: begin
        slice_upd.tp = sat_slice(slice_q.tp);
        vol_upd.tp   = sat_vol(vol_q.tp);
      end
      CLS_FN: begin
        slice_upd.fn = sat_slice(slice_q.fn);
        vol_upd.fn   = sat_vol(vol_q.fn);
      end
      CLS_FP: begin
        slice_upd.fp = sat_slice(slice_q.fp);
        vol_upd.fp   = sat_vol(vol_q.fp);
      end
      default: begin
        slice_upd.tn = sat_slice(slice_q.tn);
        vol_upd.tn   = sat_vol(vol_q.tn);
      end
    endcase

    q_job_o.cls        = cls;
    q_job_o.slice_end  = slice_end_i;
    q_job_o.volume_end = volume_end_i;
    q_job_o.slice_cnt  = slice_upd;
    q_job_o.vol_cnt    = vol_upd;

    slice_d = slice_q;
    vol_d   = vol_q;
    if (accept) begin
      slice_d = (slice_end_i || volume_end_i) ? '0 : slice_upd;
      vol_d   = volume_end_i ? '0 : vol_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= '0;
      vol_q   <= '0;
    end else begin
      slice_q <= slice_d;
      vol_q   <= vol_d;
    end
  end

endmodule

>>> sv/sod_job_queue.sv
// ----------------------------------------------------------------------------
// sod_job_queue
// Short first-in first-out queue of classified pixel jobs between the
// front and the back.
// ----------------------------------------------------------------------------
module sod_job_queue import sod_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output job_t job_o
);

  job_t             mem_q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rd_ptr_q];

  // Store the job
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

>>> sv/sod_div.sv
// ----------------------------------------------------------------------------
// sod_div
// Restoring divider for the scores: ((num << SCORE_FRAC_BITS) + den/2) / den,
// one quotient bit per cycle, SCORE_W bits in all.
// ----------------------------------------------------------------------------
module sod_div import sod_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [DIV_W-1:0]   rem_q, rem_d;
  logic [DIV_W-1:0]   dvs_q, dvs_d;
  logic [SCORE_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic               ge;

  assign ge = (rem_q >= dvs_q);

  // Load operands or take one quotient bit
  always_comb begin
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = DIV_W'({req_i.num, SCORE_FRAC_BITS'(0)}) + DIV_W'(req_i.den >> 1);
      dvs_d  = {req_i.den, SCORE_FRAC_BITS'(0)};
      quo_d  = '0;
      cnt_d  = STEP_W'(SCORE_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = rem_q - dvs_q;
      end
      quo_d = {quo_q[SCORE_W-2:0], ge};
      dvs_d = dvs_q >> 1;
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;

  // A new division never starts on top of a running one
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("divider started while busy");

  // The last step is followed by the done pulse
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (busy_q && !req_i.start && cnt_q == '0) |=> (done_q && !busy_q))
    else $error("divider missed its done pulse");

endmodule

>>> sv/sod_back.sv
// ----------------------------------------------------------------------------
// sod_back
// Takes classified jobs, emits the overlay pixel and, at slice and volume
// ends, runs the shared divider for Dice and Jaccard and emits summaries.
// Results wait in a short output queue.
// ----------------------------------------------------------------------------
module sod_back import sod_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  job_t     job_i,
  input  logic     job_empty_i,
  output logic     job_pop_o,
  output div_req_t div_req_o,
  input  div_rsp_t div_rsp_i,
  input  logic     pop_i,
  output logic     empty_o,
  output result_t  res_o
);

  back_state_e        state_q, state_d;
  job_t               job_q, job_d;
  logic               sel_vol_q, sel_vol_d;
  logic [SCORE_W-1:0] dice_q, dice_d, jac_q, jac_d;

  result_t            res_mem_q [QDEPTH];
  logic [PTR_W-1:0]   res_wr_q, res_rd_q;
  logic [CNT_W-1:0]   res_cnt_q;
  logic               res_full, res_push, res_pop;
  result_t            res_new;

  logic [VOL_CNT_W-1:0] sel_tp, sel_fp, sel_tn, sel_fn;
  logic [DEN_W-1:0]     den_j, den_d;
  logic                 ratio_ok;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Pick the counts of the summary in progress
  always_comb begin
    if (sel_vol_q) begin
      sel_tp = job_q.vol_cnt.tp;
      sel_fp = job_q.vol_cnt.fp;
      sel_tn = job_q.vol_cnt.tn;
      sel_fn = job_q.vol_cnt.fn;
    end else begin
      sel_tp = VOL_CNT_W'(job_q.slice_cnt.tp);
      sel_fp = VOL_CNT_W'(job_q.slice_cnt.fp);
      sel_tn = VOL_CNT_W'(job_q.slice_cnt.tn);
      sel_fn = VOL_CNT_W'(job_q.slice_cnt.fn);
    end
  end

  assign den_j    = DEN_W'(sel_tp) + DEN_W'(sel_fp) + DEN_W'(sel_fn);
  assign den_d    = den_j + DEN_W'(sel_tp);
  assign ratio_ok = (den_j != '0);

  assign res_full = (res_cnt_q == CNT_W'(QDEPTH));
  assign empty_o  = (res_cnt_q == '0);
  assign res_pop  = pop_i && !empty_o;
  assign res_o    = res_mem_q[res_rd_q];

  // Sequence pixels and summaries
  always_comb begin
    state_d         = state_q;
    job_d           = job_q;
    sel_vol_d       = sel_vol_q;
    dice_d          = dice_q;
    jac_d           = jac_q;
    job_pop_o       = 1'b0;
    res_push        = 1'b0;
    res_new         = '0;
    div_req_o.start = 1'b0;
    div_req_o.num   = {sel_tp, 1'b0};
    div_req_o.den   = den_d;
    unique case (state_q)
      B_IDLE: begin
        if (!job_empty_i && !res_full) begin
          job_pop_o    = 1'b1;
          res_push     = 1'b1;
          res_new.kind = KIND_PIXEL;
          case (job_i.cls)
            CLS_TP:  res_new.green = CHANNEL_ON;
            CLS_FN:  res_new.red   = CHANNEL_ON;
            CLS_FP:  res_new.blue  = CHANNEL_ON;
            default: res_new.blue  = 8'd0;
          endcase
          res_new.last = !(job_i.slice_end || job_i.volume_end);
          if (job_i.slice_end || job_i.volume_end) begin
            job_d     = job_i;
            sel_vol_d = !job_i.slice_end;
            state_d   = B_DICE_GO;
          end
        end
      end
      B_DICE_GO: begin
        div_req_o.start = 1'b1;
        state_d         = B_DICE_WAIT;
      end
      B_DICE_WAIT: begin
        if (div_rsp_i.done) begin
          dice_d  = div_rsp_i.quot;
          state_d = B_JAC_GO;
        end
      end
      B_JAC_GO: begin
        div_req_o.start = 1'b1;
        div_req_o.num   = NUM_W'(sel_tp);
        div_req_o.den   = den_j;
        state_d         = B_JAC_WAIT;
      end
      B_JAC_WAIT: begin
        if (div_rsp_i.done) begin
          jac_d   = div_rsp_i.quot;
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        if (!res_full) begin
          res_push      = 1'b1;
          res_new.kind  = sel_vol_q ? KIND_VOLUME : KIND_SLICE;
          res_new.tp    = sel_tp;
          res_new.fp    = sel_fp;
          res_new.tn    = sel_tn;
          res_new.fn    = sel_fn;
          res_new.dice  = ratio_ok ? dice_q : '0;
          res_new.jac   = ratio_ok ? jac_q : '0;
          res_new.valid = ratio_ok;
          res_new.last  = sel_vol_q || !job_q.volume_end;
          if (!sel_vol_q && job_q.volume_end) begin
            sel_vol_d = 1'b1;
            state_d   = B_DICE_GO;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // Hold the job and scores, and write results into the output queue
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    dice_q <= dice_d;
    jac_q  <= jac_d;
    if (res_push) begin
      res_mem_q[res_wr_q] <= res_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      sel_vol_q <= 1'b0;
      res_wr_q  <= '0;
      res_rd_q  <= '0;
      res_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      sel_vol_q <= sel_vol_d;
      if (res_push) begin
        res_wr_q <= ptr_next(res_wr_q);
      end
      if (res_pop) begin
        res_rd_q <= ptr_next(res_rd_q);
      end
      if (res_push && !res_pop) begin
        res_cnt_q <= res_cnt_q + CNT_W'(1);
      end else if (res_pop && !res_push) begin
        res_cnt_q <= res_cnt_q - CNT_W'(1);
      end
    end
  end

  // A result is never written into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   res_push |-> (res_cnt_q != CNT_W'(QDEPTH)))
    else $error("result queue overflow");

  // Divider results only arrive while a score is awaited
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   div_rsp_i.done |-> (state_q == B_DICE_WAIT || state_q == B_JAC_WAIT))
    else $error("unexpected divider result");

  // A new job is taken only once the previous one is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   job_pop_o |-> (state_q == B_IDLE && !div_rsp_i.busy))
    else $error("job taken while busy");

endmodule

>>> sv/segmentation_overlap_scorer_core.sv
// ----------------------------------------------------------------------------
// segmentation_overlap_scorer_core
// Top level: pixel classifier and counters, job queue, summary sequencer
// with its divider and result queue.
// ----------------------------------------------------------------------------
// Each pushed pixel pair yields an overlay pixel (green true positive, red
// false negative, blue false positive, black otherwise); the last pixel of a
// slice adds a slice summary and the last pixel of a volume a volume summary,
// each with the four saturating counts, Dice and Jaccard in unsigned Q1.16 and
// ratio_valid low on a zero denominator. A plain pixel passes through the job
// queue and then the result queue, so pixels stream at one per cycle while
// results are popped and no summary is being computed. A summary runs the
// single restoring divider, which produces one quotient bit per cycle, 17 bits
// for Dice and then 17 for Jaccard, between its go, wait and emit states; a
// pixel ending both slice and volume costs two summaries. Up to two jobs and
// two results are buffered, so input keeps being accepted while a summary is
// computed until the job queue fills.
// ----------------------------------------------------------------------------
module segmentation_overlap_scorer_core import sod_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] segmented_value_i,
  input  logic [15:0] truth_value_i,
  input  logic        slice_end_i,
  input  logic        volume_end_i,
  input  logic        push,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  result_kind_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  green_o,
  output logic [7:0]  red_o,
  output logic [27:0] true_pos_o,
  output logic [27:0] false_pos_o,
  output logic [27:0] true_neg_o,
  output logic [27:0] false_neg_o,
  output logic [16:0] dice_score_o,
  output logic [16:0] jaccard_score_o,
  output logic        ratio_valid_o,
  output logic        last_o
);

  logic     q_push, q_full, q_empty, q_pop;
  job_t     q_job_in, q_job_out;
  div_req_t div_req;
  div_rsp_t div_rsp;
  result_t  res;

  sod_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .segmented_value_i (segmented_value_i),
    .truth_value_i     (truth_value_i),
    .slice_end_i       (slice_end_i),
    .volume_end_i      (volume_end_i),
    .push_i            (push),
    .full_o            (full),
    .q_push_o          (q_push),
    .q_job_o           (q_job_in),
    .q_full_i          (q_full)
  );

  sod_job_queue u_job_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_job_out)
  );

  sod_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sod_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (q_job_out),
    .job_empty_i (q_empty),
    .job_pop_o   (q_pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (res)
  );

  // Drive the result ports
  assign result_kind_o   = res.kind;
  assign blue_o          = res.blue;
  assign green_o         = res.green;
  assign red_o           = res.red;
  assign true_pos_o      = res.tp;
  assign false_pos_o     = res.fp;
  assign true_neg_o      = res.tn;
  assign false_neg_o     = res.fn;
  assign dice_score_o    = res.dice;
  assign jaccard_score_o = res.jac;
  assign ratio_valid_o   = res.valid;
  assign last_o          = res.last;

endmodule

>>> bench/segmentation_overlap_scorer_core_tb.sv
// ----------------------------------------------------------------------------
// segmentation_overlap_scorer_core_tb
// Self-checking bench for the segmentation overlap scorer core. It streams
// pixel pairs through the push/full port, predicts every overlay pixel and
// every slice and volume summary in the bench, and compares each popped
// result field by field. The run covers directed corner pixels, random
// volumes under several idle and stall mixes, and a long receiver hold-off
// that fills the block and stalls its input.
// ----------------------------------------------------------------------------
module segmentation_overlap_scorer_core_tb import sod_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 100;

  logic        clk_i;
  logic        rst_ni;
  logic [15:0] segmented_value;
  logic [15:0] truth_value;
  logic        slice_end;
  logic        volume_end;
  logic        push;
  logic        full;
  logic        empty;
  logic        pop;
  logic [1:0]  result_kind;
  logic [7:0]  blue;
  logic [7:0]  green;
  logic [7:0]  red;
  logic [27:0] true_pos;
  logic [27:0] false_pos;
  logic [27:0] true_neg;
  logic [27:0] false_neg;
  logic [16:0] dice_score;
  logic [16:0] jaccard_score;
  logic        ratio_valid;
  logic        last;

  // Predicted state of the running tallies
  slice_cnt_t slice_tally;
  vol_cnt_t   volume_tally;

  // Results predicted but not yet popped, oldest first
  result_t pending_results[$];

  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;
  bit hold_req;
  int cycle_count;
  int mismatches;
  int pixels_sent;
  int full_stalls;
  int pixels_seen;
  int slices_seen;
  int volumes_seen;

  segmentation_overlap_scorer_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .segmented_value_i (segmented_value),
    .truth_value_i     (truth_value),
    .slice_end_i       (slice_end),
    .volume_end_i      (volume_end),
    .push              (push),
    .full              (full),
    .empty             (empty),
    .pop               (pop),
    .result_kind_o     (result_kind),
    .blue_o            (blue),
    .green_o           (green),
    .red_o             (red),
    .true_pos_o        (true_pos),
    .false_pos_o       (false_pos),
    .true_neg_o        (true_neg),
    .false_neg_o       (false_neg),
    .dice_score_o      (dice_score),
    .jaccard_score_o   (jaccard_score),
    .ratio_valid_o     (ratio_valid),
    .last_o            (last)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("segmentation_overlap_scorer_core_tb: errors");
      $finish;
    end
  end

  // Saturating counter steps
  function automatic logic [SLICE_CNT_W-1:0] inc_slice(input logic [SLICE_CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic logic [VOL_CNT_W-1:0] inc_volume(input logic [VOL_CNT_W-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  // Rounded ratio in Q1.16, ties upward, zero on an empty denominator
  function automatic logic [SCORE_W-1:0] q16_ratio(input longint unsigned num,
                                                    input longint unsigned den);
    if (den == 0) return '0;
    return SCORE_W'(((num << SCORE_FRAC_BITS) + (den >> 1)) / den);
  endfunction

  function automatic result_t summary_of(input logic [1:0] kind,
                                         input logic [VOL_CNT_W-1:0] tp,
                                         input logic [VOL_CNT_W-1:0] fp,
                                         input logic [VOL_CNT_W-1:0] tn,
                                         input logic [VOL_CNT_W-1:0] fn);
    result_t r;
    longint unsigned union_cnt;
    r = '0;
    union_cnt = longint'(tp) + longint'(fp) + longint'(fn);
    r.kind  = kind;
    r.tp    = tp;
    r.fp    = fp;
    r.tn    = tn;
    r.fn    = fn;
    r.dice  = q16_ratio(2 * longint'(tp), union_cnt + longint'(tp));
    r.jac   = q16_ratio(longint'(tp), union_cnt);
    r.valid = (union_cnt != 0);
    return r;
  endfunction

  // Append one predicted result behind the ones already waiting
  task automatic queue_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Classify one pixel, update the tallies and queue the results it causes
  task automatic predict_pixel(input logic [15:0] seg, input logic [15:0] gt,
                               input logic s_end, input logic v_end);
    pix_class_e cls;
    result_t    px;
    result_t    sm;
    if (gt != 0 && seg != 0) cls = CLS_TP;
    else if (gt != 0)        cls = CLS_FN;
    else if (seg != 0)       cls = CLS_FP;
    else                     cls = CLS_TN;
    px = '0;
    px.kind = KIND_PIXEL;
    case (cls)
      CLS_TP: begin
        px.green = CHANNEL_ON;
        slice_tally.tp  = inc_slice(slice_tally.tp);
        volume_tally.tp = inc_volume(volume_tally.tp);
      end
      CLS_FN: begin
        px.red = CHANNEL_ON;
        slice_tally.fn  = inc_slice(slice_tally.fn);
        volume_tally.fn = inc_volume(volume_tally.fn);
      end
      CLS_FP: begin
        px.blue = CHANNEL_ON;
        slice_tally.fp  = inc_slice(slice_tally.fp);
        volume_tally.fp = inc_volume(volume_tally.fp);
      end
      default: begin
        slice_tally.tn  = inc_slice(slice_tally.tn);
        volume_tally.tn = inc_volume(volume_tally.tn);
      end
    endcase
    px.last = !(s_end || v_end);
    queue_result(px);
    if (s_end) begin
      sm = summary_of(KIND_SLICE, slice_tally.tp, slice_tally.fp,
                      slice_tally.tn, slice_tally.fn);
      sm.last = !v_end;
      queue_result(sm);
    end
    if (v_end) begin
      sm = summary_of(KIND_VOLUME, volume_tally.tp, volume_tally.fp,
                      volume_tally.tn, volume_tally.fn);
      sm.last = 1'b1;
      queue_result(sm);
      volume_tally = '0;
    end
    // A volume end also clears the slice tallies
    if (s_end || v_end) slice_tally = '0;
  endtask

  // Offer one pixel pair and hold it until the block takes it
  task automatic send_pixel(input logic [15:0] seg, input logic [15:0] gt,
                            input logic s_end, input logic v_end);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push            <= 1'b1;
    segmented_value <= seg;
    truth_value     <= gt;
    slice_end       <= s_end;
    volume_end      <= v_end;
    @(posedge clk_i);
    while (full) begin
      full_stalls++;
      @(posedge clk_i);
    end
    predict_pixel(seg, gt, s_end, v_end);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  // Stop offering and wait until every predicted result has been popped
  task automatic wait_drained(input int settle);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_sample(input int pct);
    if ($urandom_range(99) >= pct) return 16'h0000;
    case ($urandom_range(2))
      0:       return 16'hFFFF;
      1:       return 16'h0001 << $urandom_range(15);
      default: return 16'($urandom_range(65535, 1));
    endcase
  endfunction

  // Random volumes made of short slices, with some stray end flags mixed in
  task automatic run_random_volumes(input int n_items);
    int sent;
    int n_slices;
    int slice_len;
    int seg_pct;
    int gt_pct;
    bit px_last;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(9) == 0) begin
        send_pixel(rand_sample(50), rand_sample(50), 1'($urandom_range(1)),
                   1'($urandom_range(1)));
        sent++;
      end else begin
        n_slices = $urandom_range(1, 4);
        for (int s = 0; s < n_slices; s++) begin
          slice_len = ($urandom_range(15) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 6);
          seg_pct = $urandom_range(4) * 25;
          gt_pct  = $urandom_range(4) * 25;
          for (int p = 0; p < slice_len; p++) begin
            px_last = (p == slice_len - 1);
            send_pixel(rand_sample(seg_pct), rand_sample(gt_pct), px_last,
                       px_last && (s == n_slices - 1));
            sent++;
          end
        end
      end
    end
  endtask

  // Corner pixels: every class, both end flags alone and together
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_pixel(16'h0000, 16'h0000, 1'b1, 1'b0);  // all-negative slice, no ratio
    send_pixel(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'h0000, 16'hFFFF, 1'b0, 1'b0);
    send_pixel(16'h0000, 16'h0000, 1'b0, 1'b0);
    send_pixel(16'h0001, 16'h8000, 1'b1, 1'b0);  // mixed slice, Dice two thirds rounded, Jaccard one half
    send_pixel(16'h0000, 16'h0000, 1'b0, 1'b1);  // volume end without slice end
    send_pixel(16'h0001, 16'h0001, 1'b1, 1'b1);  // perfect overlap, score 1.0
    send_pixel(16'h0000, 16'h0000, 1'b1, 1'b1);  // empty volume
    send_pixel(16'h8000, 16'h0000, 1'b1, 1'b0);  // false positives only
    send_pixel(16'h0000, 16'h0001, 1'b1, 1'b1);
    send_pixel(16'hAAAA, 16'h5555, 1'b0, 1'b0);
    send_pixel(16'h5555, 16'hAAAA, 1'b1, 1'b1);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Random volumes under each idle and stall mix
  task automatic test_random_streaming();
    send_idle_pct = 0;  recv_stall_pct = 0;
    run_random_volumes(50);
    send_idle_pct = 51; recv_stall_pct = 0;
    run_random_volumes(50);
    send_idle_pct = 0;  recv_stall_pct = 51;
    run_random_volumes(50);
    send_idle_pct = 21; recv_stall_pct = 21;
    run_random_volumes(50);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block fills
  task automatic test_full_stall();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len = 400;
    hold_req = 1'b1;
    run_random_volumes(24);
    wait_drained(SETTLE_CYCLES);
  endtask

  // Receiver: random pop, with a counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = hold_len;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        pop <= 1'b0;
        hold_left--;
      end else begin
        pop <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each popped transaction with the oldest prediction
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result popped with nothing predicted: kind %0d", result_kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.kind, result_kind);
        check_field("blue", want.blue, blue);
        check_field("green", want.green, green);
        check_field("red", want.red, red);
        check_field("true_pos", want.tp, true_pos);
        check_field("false_pos", want.fp, false_pos);
        check_field("true_neg", want.tn, true_neg);
        check_field("false_neg", want.fn, false_neg);
        check_field("dice_score", want.dice, dice_score);
        check_field("jaccard_score", want.jac, jaccard_score);
        check_field("ratio_valid", want.valid, ratio_valid);
        check_field("last", want.last, last);
        case (want.kind)
          KIND_SLICE:  slices_seen++;
          KIND_VOLUME: volumes_seen++;
          default:     pixels_seen++;
        endcase
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni          = 1'b0;
    push            = 1'b0;
    segmented_value = '0;
    truth_value     = '0;
    slice_end       = 1'b0;
    volume_end      = 1'b0;
    hold_req        = 1'b0;
    hold_len        = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    mismatches      = 0;
    pixels_sent     = 0;
    full_stalls     = 0;
    pixels_seen     = 0;
    slices_seen     = 0;
    volumes_seen    = 0;
    slice_tally     = '0;
    volume_tally    = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_random_streaming();
    test_full_stall();

    $display("Sent %0d pixels; checked %0d overlay pixels, %0d slice and %0d volume summaries.",
             pixels_sent, pixels_seen, slices_seen, volumes_seen);
    $display("Input held off by a full block for %0d cycles.", full_stalls);
    if (mismatches == 0) begin
      $display("segmentation_overlap_scorer_core_tb: clean");
    end else begin
      $display("segmentation_overlap_scorer_core_tb: errors");
    end
    $finish;
  end

endmodule
